// File: hdl/radial_dead_zone_stick_top_macros.svh
// Assertion macros for the radial dead zone stick block.
// Included by radial_dead_zone_stick_top; needs no other file.
`ifndef RADIAL_DEAD_ZONE_STICK_TOP_MACROS_SVH
`define RADIAL_DEAD_ZONE_STICK_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define RDZ_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rdz: same-cycle check failed");
`define RDZ_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rdz: next-cycle check failed");
`else
`define RDZ_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define RDZ_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// File: hdl/rdz_pkg.sv
// Package for the radial dead zone stick block: field widths, defaults,
// register indexes and the CORDIC arctangent table. No dependencies.
`timescale 1ns / 1ps
package rdz_pkg;
  localparam int SAMPLE_BITS_DEF   = 16;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int MAG_W  = 16;
  localparam int ANG_W  = 15;
  localparam int CFG_W  = 16;
  localparam int ATAN_N = 24;
  localparam logic [MAG_W-1:0] ONE_Q15 = 16'h8000;
  localparam int ANGLE_LIMIT = 11520;
  localparam logic signed [ANG_W-1:0] ANGLE_MAX = 15'sd11520;
  localparam logic signed [ANG_W-1:0] ANGLE_MIN = -15'sd11520;
  // half turn in 1/16384 degree
  localparam int HALF_TURN = 2949120;
  localparam logic CFG_INNER = 1'b0;
  localparam logic CFG_OUTER = 1'b1;
  // atan(2^-i) in 1/16384 degree
  localparam logic [19:0] ATAN_TAB [ATAN_N] = '{
    20'd737280, 20'd435242, 20'd229970, 20'd116736, 20'd58595, 20'd29326,
    20'd14667, 20'd7334, 20'd3667, 20'd1833, 20'd917, 20'd458,
    20'd229, 20'd115, 20'd57, 20'd29, 20'd14, 20'd7,
    20'd4, 20'd2, 20'd1, 20'd0, 20'd0, 20'd0
  };
endpackage

// File: hdl/radial_dead_zone_stick_top.sv
// Radial dead zone for one analog stick: pipelined length, angle and rescale.
// Depends on rdz_pkg and radial_dead_zone_stick_top_macros.svh.
//
// Usage: raw x and y enter on the s_ channel, one item per cycle at most.
// Each item yields one result on the m_ channel: corrected x and y, the
// remapped radius and the raw angle. The length is a bit-per-stage square
// root (SAMPLE_BITS+8 stages), the radius and the rescaled axes come from
// bit-per-stage dividers (16 stages each), the angle from a CORDIC_STAGES
// deep CORDIC running beside them. Throughput is one item per cycle for as
// long as m_tready stays high. Configuration (inner_fraction index 0,
// outer_fraction index 1) is written through cfg_we / cfg_index /
// cfg_data; the user must write it only while the pipeline is empty,
// which the block itself does not enforce. Reset clears all valid bits,
// sets inner 0 and outer 32768.
// When the receiver stalls, one extra result lands in a skid register and
// then the whole pipeline freezes with s_tready low; nothing is dropped.
`timescale 1ns / 1ps
`include "radial_dead_zone_stick_top_macros.svh"
module radial_dead_zone_stick_top #(
  parameter int SAMPLE_BITS   = rdz_pkg::SAMPLE_BITS_DEF,
  parameter int CORDIC_STAGES = rdz_pkg::CORDIC_STAGES_DEF,
  localparam int IN_W  = ((2 * SAMPLE_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((2 * SAMPLE_BITS + 38) / 8) * 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [IN_W-1:0]          s_tdata,   // raw_x, raw_y
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [OUT_W-1:0]         m_tdata,   // corrected_x, corrected_y, magnitude, angle
  input  logic                     cfg_we,
  input  logic [0:0]               cfg_index,
  input  logic [rdz_pkg::CFG_W-1:0] cfg_data
);
  import rdz_pkg::*;

  localparam int SB  = SAMPLE_BITS;
  localparam int CS  = CORDIC_STAGES;
  localparam int LW  = SB + 8;
  localparam int RW  = 2 * LW;
  localparam int QW  = 16;
  localparam int RNW = LW + 17;
  localparam int SNW = SB + 25;
  localparam int CW  = SB + 19;
  localparam int ZW  = 25;
  localparam int EW  = SB + QW + 2;
  localparam int OD  = 2 * SB + MAG_W + ANG_W;
  localparam int P_SQRT0 = 3;
  localparam int P_RAD0  = P_SQRT0 + LW;
  localparam int P_RFIN  = P_RAD0 + QW + 1;
  localparam int P_MUL   = P_RFIN + 1;
  localparam int P_OUT   = P_MUL + QW + 1;
  localparam int NST     = P_OUT + 1;
  localparam int P_ANG   = CS + 2;
  localparam logic signed [EW-1:0] SHI = EW'((64'sd1 <<< (SB - 1)) - 64'sd1);
  localparam logic signed [EW-1:0] SLO = ~SHI;

  logic en;
  logic [NST-1:0] v;
  logic [CFG_W-1:0] inner_fraction, outer_fraction;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      inner_fraction <= '0;
      outer_fraction <= ONE_Q15;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_INNER: inner_fraction <= cfg_data;
        CFG_OUTER: outer_fraction <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[NST-2:0], s_tvalid};
    end
  end

  // ---------------- sample line and squares ----------------
  logic signed [SB-1:0] xs [0:P_RFIN];
  logic signed [SB-1:0] ys [0:P_RFIN];
  logic signed [2*SB-1:0] xsq, ysq;
  logic [2*SB-1:0] xx, yy;
  logic [RW-1:0] rad;

  assign xsq = xs[0] * xs[0];
  assign ysq = ys[0] * ys[0];

  always_ff @(posedge clk) begin
    if (en) begin
      xs[0] <= s_tdata[SB-1:0];
      ys[0] <= s_tdata[2*SB-1:SB];
      for (int k = 1; k <= P_RFIN; k++) begin
        xs[k] <= xs[k-1];
        ys[k] <= ys[k-1];
      end
      xx  <= $unsigned(xsq);
      yy  <= $unsigned(ysq);
      rad <= {xx + yy, 16'd0};
    end
  end

  // ---------------- square root, one result bit per stage ----------------
  logic [RW-1:0] srem  [LW];
  logic [LW-1:0] sroot [LW];

  for (genvar k = 0; k < LW; k++) begin : g_sqrt
    localparam int B = LW - 1 - k;
    logic [RW-1:0] prem;
    logic [LW-1:0] proot;
    logic [RW:0]   trial;
    if (k == 0) begin : g_first
      assign prem  = rad;
      assign proot = '0;
    end else begin : g_next
      assign prem  = srem[k-1];
      assign proot = sroot[k-1];
    end
    assign trial = ((RW + 1)'(proot) << (B + 1)) | ((RW + 1)'(1) << (2 * B));
    always_ff @(posedge clk) begin
      if (en) begin
        if ({1'b0, prem} >= trial) begin
          srem[k]  <= prem - trial[RW-1:0];
          sroot[k] <= proot | (LW'(1) << B);
        end else begin
          srem[k]  <= prem;
          sroot[k] <= proot;
        end
      end
    end
  end

  // ---------------- radius remap ----------------
  logic [LW-1:0] lens [P_RAD0:P_RFIN];
  logic [LW-1:0] rlen, ti, tou, rdiff, rden_c;
  logic [RNW-1:0] rnum;
  logic [LW-1:0]  rden;
  logic rfix, rfull;

  assign rlen   = sroot[LW-1];
  assign ti     = LW'(inner_fraction) << (SB - 8);
  assign tou    = LW'(outer_fraction) << (SB - 8);
  assign rdiff  = rlen - ti;
  assign rden_c = tou - ti;

  always_ff @(posedge clk) begin
    if (en) begin
      lens[P_RAD0] <= rlen;
      for (int k = P_RAD0 + 1; k <= P_RFIN; k++) lens[k] <= lens[k-1];
      rnum <= (RNW'(rdiff) << 15) + RNW'(rden_c >> 1);
      rden <= rden_c;
      priority if (tou <= ti) begin
        rfix  <= 1'b1;
        rfull <= rlen >= ti;
      end else if (rlen <= ti) begin
        rfix  <= 1'b1;
        rfull <= 1'b0;
      end else if (rdiff >= rden_c) begin
        rfix  <= 1'b1;
        rfull <= 1'b1;
      end else begin
        rfix  <= 1'b0;
        rfull <= 1'b0;
      end
    end
  end

  logic [RNW-1:0] rrem  [QW];
  logic [QW-1:0]  rq    [QW];
  logic [LW-1:0]  rdenv [QW];
  logic [QW-1:0]  rfixv, rfullv;

  for (genvar j = 0; j < QW; j++) begin : g_rdiv
    localparam int B = QW - 1 - j;
    logic [RNW-1:0] prem, dsh;
    logic [QW-1:0]  pq;
    logic [LW-1:0]  pden;
    logic pfix, pfull;
    if (j == 0) begin : g_first
      assign prem  = rnum;
      assign pq    = '0;
      assign pden  = rden;
      assign pfix  = rfix;
      assign pfull = rfull;
    end else begin : g_next
      assign prem  = rrem[j-1];
      assign pq    = rq[j-1];
      assign pden  = rdenv[j-1];
      assign pfix  = rfixv[j-1];
      assign pfull = rfullv[j-1];
    end
    assign dsh = RNW'(pden) << B;
    always_ff @(posedge clk) begin
      if (en) begin
        rdenv[j]  <= pden;
        rfixv[j]  <= pfix;
        rfullv[j] <= pfull;
        if (prem >= dsh) begin
          rrem[j] <= prem - dsh;
          rq[j]   <= pq | (QW'(1) << B);
        end else begin
          rrem[j] <= prem;
          rq[j]   <= pq;
        end
      end
    end
  end

  logic [MAG_W-1:0] rr [P_RFIN:P_OUT];

  always_ff @(posedge clk) begin
    if (en) begin
      if (rfixv[QW-1]) begin
        rr[P_RFIN] <= rfullv[QW-1] ? ONE_Q15 : '0;
      end else begin
        rr[P_RFIN] <= (rq[QW-1] > ONE_Q15) ? ONE_Q15 : rq[QW-1];
      end
      for (int k = P_RFIN + 1; k <= P_OUT; k++) rr[k] <= rr[k-1];
    end
  end

  // ---------------- rescale x and y by r / len ----------------
  logic [SB-1:0] ax, ay;
  logic [SB+15:0] mx, my;
  logic [SNW-1:0] xnum, ynum;
  logic [LW-1:0] sden;
  logic snx, sny, szero;

  assign ax = xs[P_RFIN][SB-1] ? (~$unsigned(xs[P_RFIN]) + SB'(1)) : $unsigned(xs[P_RFIN]);
  assign ay = ys[P_RFIN][SB-1] ? (~$unsigned(ys[P_RFIN]) + SB'(1)) : $unsigned(ys[P_RFIN]);
  assign mx = ax * rr[P_RFIN];
  assign my = ay * rr[P_RFIN];

  always_ff @(posedge clk) begin
    if (en) begin
      xnum  <= (SNW'(mx) << 8) + SNW'(lens[P_RFIN] >> 1);
      ynum  <= (SNW'(my) << 8) + SNW'(lens[P_RFIN] >> 1);
      sden  <= lens[P_RFIN];
      snx   <= xs[P_RFIN][SB-1];
      sny   <= ys[P_RFIN][SB-1];
      szero <= lens[P_RFIN] == '0;
    end
  end

  logic [SNW-1:0] xrem [QW];
  logic [SNW-1:0] yrem [QW];
  logic [QW-1:0]  xq   [QW];
  logic [QW-1:0]  yq   [QW];
  logic [LW-1:0]  sdenv [QW];
  logic [QW-1:0]  snxv, snyv, szv;

  for (genvar j = 0; j < QW; j++) begin : g_sdiv
    localparam int B = QW - 1 - j;
    logic [SNW-1:0] pxr, pyr, dsh;
    logic [QW-1:0]  pxq, pyq;
    logic [LW-1:0]  pden;
    logic pnx, pny, pz;
    if (j == 0) begin : g_first
      assign pxr  = xnum;
      assign pyr  = ynum;
      assign pxq  = '0;
      assign pyq  = '0;
      assign pden = sden;
      assign pnx  = snx;
      assign pny  = sny;
      assign pz   = szero;
    end else begin : g_next
      assign pxr  = xrem[j-1];
      assign pyr  = yrem[j-1];
      assign pxq  = xq[j-1];
      assign pyq  = yq[j-1];
      assign pden = sdenv[j-1];
      assign pnx  = snxv[j-1];
      assign pny  = snyv[j-1];
      assign pz   = szv[j-1];
    end
    assign dsh = SNW'(pden) << B;
    always_ff @(posedge clk) begin
      if (en) begin
        sdenv[j] <= pden;
        snxv[j]  <= pnx;
        snyv[j]  <= pny;
        szv[j]   <= pz;
        if (pxr >= dsh) begin
          xrem[j] <= pxr - dsh;
          xq[j]   <= pxq | (QW'(1) << B);
        end else begin
          xrem[j] <= pxr;
          xq[j]   <= pxq;
        end
        if (pyr >= dsh) begin
          yrem[j] <= pyr - dsh;
          yq[j]   <= pyq | (QW'(1) << B);
        end else begin
          yrem[j] <= pyr;
          yq[j]   <= pyq;
        end
      end
    end
  end

  function automatic logic [SB-1:0] sat_comp(input logic [QW-1:0] q, input logic neg);
    logic signed [EW-1:0] val;
    val = $signed({{(EW - QW){1'b0}}, q});
    if (neg) val = -val;
    if (val > SHI) return SHI[SB-1:0];
    if (val < SLO) return SLO[SB-1:0];
    return val[SB-1:0];
  endfunction

  logic [SB-1:0] ocx, ocy;

  always_ff @(posedge clk) begin
    if (en) begin
      ocx <= szv[QW-1] ? '0 : sat_comp(xq[QW-1], snxv[QW-1]);
      ocy <= szv[QW-1] ? '0 : sat_comp(yq[QW-1], snyv[QW-1]);
    end
  end

  // ---------------- angle: vectoring CORDIC ----------------
  logic signed [CW-1:0] cxa [CS+1];
  logic signed [CW-1:0] cya [CS+1];
  logic signed [ZW-1:0] za  [CS+1];
  logic signed [CW-1:0] ex, ey;

  assign ex = CW'(xs[0]) <<< 16;
  assign ey = CW'(ys[0]) <<< 16;

  // rotate left half plane by a half turn first
  always_ff @(posedge clk) begin
    if (en) begin
      if (xs[0][SB-1]) begin
        cxa[0] <= -ex;
        cya[0] <= -ey;
        za[0]  <= ys[0][SB-1] ? -ZW'(HALF_TURN) : ZW'(HALF_TURN);
      end else begin
        cxa[0] <= ex;
        cya[0] <= ey;
        za[0]  <= '0;
      end
    end
  end

  for (genvar i = 0; i < CS; i++) begin : g_cordic
    logic signed [CW-1:0] dx, dy;
    logic signed [ZW-1:0] at;
    assign dx = cya[i] >>> i;
    assign dy = cxa[i] >>> i;
    assign at = $signed(ZW'(ATAN_TAB[i]));
    always_ff @(posedge clk) begin
      if (en) begin
        if (!cya[i][CW-1]) begin
          cxa[i+1] <= cxa[i] + dx;
          cya[i+1] <= cya[i] - dy;
          za[i+1]  <= za[i] + at;
        end else begin
          cxa[i+1] <= cxa[i] - dx;
          cya[i+1] <= cya[i] + dy;
          za[i+1]  <= za[i] - at;
        end
      end
    end
  end

  logic signed [ZW-1:0] zr;
  logic signed [ANG_W-1:0] ang_d [P_ANG:P_OUT];

  assign zr = (za[CS] + $signed(ZW'(128))) >>> 8;

  always_ff @(posedge clk) begin
    if (en) begin
      priority if (xs[CS+1] == '0 && ys[CS+1] == '0) begin
        ang_d[P_ANG] <= '0;
      end else if (zr > ZW'(ANGLE_LIMIT)) begin
        ang_d[P_ANG] <= ANGLE_MAX;
      end else if (zr < -ZW'(ANGLE_LIMIT)) begin
        ang_d[P_ANG] <= ANGLE_MIN;
      end else begin
        ang_d[P_ANG] <= zr[ANG_W-1:0];
      end
      for (int k = P_ANG + 1; k <= P_OUT; k++) ang_d[k] <= ang_d[k-1];
    end
  end

  // ---------------- output register with skid ----------------
  logic [OUT_W-1:0] pdata, out_d, skid_d;
  logic out_v, skid_v;

  assign pdata = {{(OUT_W - OD){1'b0}}, ang_d[P_OUT], rr[P_OUT], ocy, ocx};
  assign en       = !skid_v;
  assign s_tready = en;
  assign m_tvalid = out_v;
  assign m_tdata  = out_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (skid_v) begin
      if (m_tready) begin
        out_d  <= skid_d;
        skid_v <= 1'b0;
      end
    end else if (v[NST-1]) begin
      if (!out_v || m_tready) begin
        out_d <= pdata;
        out_v <= 1'b1;
      end else begin
        skid_d <= pdata;
        skid_v <= 1'b1;
      end
    end else if (m_tready) begin
      out_v <= 1'b0;
    end
  end

  `RDZ_ASSERT_IMP(a_skid_has_out, clk, rst, skid_v, out_v)
  `RDZ_ASSERT_NXT(a_stall_holds_pipe, clk, rst, !en, $stable(v))
  `RDZ_ASSERT_NXT(a_skid_fills, clk, rst, out_v && !m_tready && v[NST-1] && en, skid_v)
  `RDZ_ASSERT_IMP(a_mag_range, clk, rst, out_v, out_d[2*SB+MAG_W-1:2*SB] <= ONE_Q15)
  `RDZ_ASSERT_IMP(a_ang_range, clk, rst, out_v, $signed(out_d[OD-1:OD-ANG_W]) <= ANGLE_MAX && $signed(out_d[OD-1:OD-ANG_W]) >= ANGLE_MIN)

endmodule

// File: tb/radial_dead_zone_stick_top_tb.sv
// Self-checking testbench for radial_dead_zone_stick_top: random and corner stick samples,
// a built-in predictor of length, remap, rescale and CORDIC angle. Needs rdz_pkg and the RTL.
`timescale 1ns / 1ps
module radial_dead_zone_stick_top_tb;
  import rdz_pkg::*;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
  } stick_t;

  typedef struct {
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic [MAG_W-1:0] mag;
    logic signed [ANG_W-1:0] angle;
  } corr_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [31:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = CFG_INNER;
  logic [CFG_W-1:0] cfg_data = '0;

  stick_t sample_q[$];
  corr_t corrected_q[$];
  longint inner_r = 0;
  longint outer_r = 32768;
  bit idle_en = 1'b1;
  int src_gap = 0;
  int snk_gap = 0;
  int stall_cnt = 0;
  int err_cnt = 0;
  stick_t nxt;
  corr_t got, want;

  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 120;

  radial_dead_zone_stick_top DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic longint scale_axis(longint c, longint r, longint len);
    longint mag, q, v;
    mag = (c < 0) ? -c : c;
    q = (mag * r * 256 + len / 2) / len;
    v = (c < 0) ? -q : q;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v;
  endfunction

  function automatic corr_t remap_stick(logic signed [15:0] rx, logic signed [15:0] ry);
    longint x, y, v, res, b, len, t_in, t_out, r, den, cx, cy, z, dx, dy, a;
    corr_t o;
    x = rx;
    y = ry;
    v = (x * x + y * y) << 16;
    res = 0;
    b = 64'sd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    len = res;
    t_in = inner_r << 8;
    t_out = outer_r << 8;
    if (t_out <= t_in) r = (len >= t_in) ? 32768 : 0;
    else if (len <= t_in) r = 0;
    else begin
      den = t_out - t_in;
      r = ((len - t_in) * 32768 + den / 2) / den;
      if (r > 32768) r = 32768;
    end
    o.cx = (len != 0) ? 16'(scale_axis(x, r, len)) : '0;
    o.cy = (len != 0) ? 16'(scale_axis(y, r, len)) : '0;
    o.mag = r[15:0];
    a = 0;
    if (x != 0 || y != 0) begin
      // vectoring CORDIC, left half plane folded by a half turn
      cx = x * 65536;
      cy = y * 65536;
      z = 0;
      if (x < 0) begin
        cx = -cx;
        cy = -cy;
        z = (y >= 0) ? HALF_TURN : -HALF_TURN;
      end
      for (int i = 0; i < CORDIC_STAGES_DEF && i < ATAN_N; i++) begin
        dx = cy >>> i;
        dy = cx >>> i;
        if (cy >= 0) begin
          cx = cx + dx; cy = cy - dy; z = z + longint'(ATAN_TAB[i]);
        end else begin
          cx = cx - dx; cy = cy + dy; z = z - longint'(ATAN_TAB[i]);
        end
      end
      a = (z + 128) >>> 8;
      if (a > ANGLE_LIMIT) a = ANGLE_LIMIT;
      if (a < -ANGLE_LIMIT) a = -ANGLE_LIMIT;
    end
    o.angle = a[ANG_W-1:0];
    return o;
  endfunction

  // sender
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      src_gap <= 0;
    end else if (!s_tvalid || s_tready) begin
      if (src_gap > 0) begin
        src_gap <= src_gap - 1;
        s_tvalid <= 1'b0;
      end else if (sample_q.size() > 0) begin
        nxt = sample_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= {nxt.y, nxt.x};
        if (idle_en && $urandom_range(0, 15) == 0) src_gap <= $urandom_range(1, 18);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver backpressure
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      snk_gap <= 0;
    end else if (snk_gap > 0) begin
      snk_gap <= snk_gap - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if (idle_en && $urandom_range(0, 11) == 0) snk_gap <= $urandom_range(1, 18);
    end
  end

  // prediction on accept, compare on result, watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) corrected_q.push_back(remap_stick(s_tdata[15:0], s_tdata[31:16]));
      if (m_tvalid && m_tready) begin
        got.cx = m_tdata[15:0];
        got.cy = m_tdata[31:16];
        got.mag = m_tdata[47:32];
        got.angle = m_tdata[62:48];
        if (corrected_q.size() == 0) begin
          $display("%0t: unexpected item, actual %h", $time, m_tdata);
          err_cnt++;
        end else begin
          want = corrected_q.pop_front();
          if (got.cx !== want.cx) begin
            $display("%0t: corrected_x expected %0d actual %0d", $time, want.cx, got.cx);
            err_cnt++;
          end
          if (got.cy !== want.cy) begin
            $display("%0t: corrected_y expected %0d actual %0d", $time, want.cy, got.cy);
            err_cnt++;
          end
          if (got.mag !== want.mag) begin
            $display("%0t: magnitude expected %0d actual %0d", $time, want.mag, got.mag);
            err_cnt++;
          end
          if (got.angle !== want.angle) begin
            $display("%0t: angle expected %0d actual %0d", $time, want.angle, got.angle);
            err_cnt++;
          end
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cnt <= 0;
      else stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("radial_dead_zone_stick_top regression: fail");
        $finish;
      end
    end
  end

  task automatic wait_idle();
    @(posedge clk);
    #1;
    while (sample_q.size() != 0 || corrected_q.size() != 0 || s_tvalid) begin
      @(posedge clk);
      #1;
    end
  endtask

  task automatic set_band(int unsigned inner, int unsigned outer);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_INNER;
    cfg_data <= inner[15:0];
    inner_r = inner & 16'hFFFF;
    @(posedge clk);
    cfg_index <= CFG_OUTER;
    cfg_data <= outer[15:0];
    outer_r = outer & 16'hFFFF;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_sample(int x, int y);
    stick_t s;
    s.x = x[15:0];
    s.y = y[15:0];
    sample_q.push_back(s);
  endtask

  // mix of full-range, tiny and near-threshold samples
  task automatic push_random(int n);
    int mode, rad, xx, yy;
    for (int k = 0; k < n; k++) begin
      mode = $urandom_range(0, 3);
      if (mode == 0) begin
        push_sample($urandom_range(0, 65535), $urandom_range(0, 65535));
      end else if (mode == 1) begin
        push_sample(int'($urandom_range(0, 600)) - 300, int'($urandom_range(0, 600)) - 300);
      end else begin
        rad = (mode == 2) ? int'(inner_r) : int'(outer_r);
        rad = rad + int'($urandom_range(0, 400)) - 200;
        if (rad < 0) rad = 0;
        if (rad > 32767) rad = 32767;
        xx = int'($urandom_range(0, rad));
        yy = rad - xx;
        if ($urandom_range(0, 1)) xx = -xx;
        if ($urandom_range(0, 1)) yy = -yy;
        if ($urandom_range(0, 1)) push_sample(xx, yy);
        else push_sample(yy, xx);
      end
    end
  endtask

  int unsigned band_in[8] = '{0, 8192, 0, 32768, 16384, 65535, 1000, 0};
  int unsigned band_out[8] = '{32768, 24576, 0, 32768, 8192, 40000, 65535, 1};

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    for (int ph = 0; ph < 8; ph++) begin
      wait_idle();
      set_band(band_in[ph], band_out[ph]);
      idle_en = (ph != 1 && ph != 7);
      if (ph == 0) begin
        push_sample(0, 0);
        push_sample(32767, 0);
        push_sample(-32768, 0);
        push_sample(0, 32767);
        push_sample(0, -32768);
        push_sample(-32768, -32768);
        push_sample(32767, 32767);
        push_sample(-32768, 32767);
        push_sample(32767, -32768);
        push_sample(-1, 0);
        push_sample(-1, -1);
        push_sample(1, 0);
        push_sample(0, 1);
        push_sample(-5, 0);
        push_sample(100, -1);
        push_sample(-100, -1);
        push_sample(23170, 23170);
        push_sample(-12000, 9000);
      end
      if (ph == 3) begin
        // sender pauses here until every result is back
        push_random(90);
        wait_idle();
        push_random(100);
      end else begin
        push_random(190);
      end
    end
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0 && corrected_q.size() == 0) begin
      $display("radial_dead_zone_stick_top regression: pass");
    end else begin
      $display("radial_dead_zone_stick_top regression: fail");
    end
    $finish;
  end
endmodule

// File: sim.f
+incdir+hdl
hdl/rdz_pkg.sv
hdl/radial_dead_zone_stick_top.sv
tb/radial_dead_zone_stick_top_tb.sv
